[rtl/hse_pkg.sv]
package hse_pkg;

	// Serial divider widths: dividend is |q| * 2^16 or |d| * 2^32, divisor is |h|
	localparam int DVD_W = 80;
	localparam int DEN_W = 33;

	// Clip bound for the multiplier result, Horner sums and t, +-(2^62 - 1)
	localparam logic signed [63:0] LIM = 64'sh3FFF_FFFF_FFFF_FFFF;

	// One knot as stored in the table
	typedef struct packed {
		logic [31:0] slope;
		logic [31:0] y;
		logic [31:0] x;
	} knot_t;

	// Status of a multi-cycle arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD0,
		S_RDN,
		S_SCHK,
		S_SCMP,
		S_K0,
		S_K1,
		S_CA,
		S_CB,
		S_CC,
		S_TDIV,
		S_MST,
		S_MUL,
		S_GDIV,
		S_FIN
	} seq_state_t;

	// Horner steps, named by what each step multiplies and adds
	typedef enum logic [2:0] {
		HS_V_CUBE,
		HS_V_QUAD,
		HS_V_LIN,
		HS_G_QUAD,
		HS_G_LIN
	} horner_step_t;

endpackage

[rtl/hse_knot_mem.sv]
module hse_knot_mem import hse_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  knot_t         wdata,
	input  logic [AW-1:0] raddr,
	output knot_t         rdata
);

	knot_t mem_q [DEPTH];

	// Write one knot per load request
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, data appears in the cycle after the address
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/hse_div.sv]
module hse_div import hse_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic [DVD_W-1:0] quotient,
	output unit_stat_t       stat
);

	localparam int CNT_W = $clog2(DVD_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DVD_W-1:0]   work_q;
	logic [DEN_W-1:0]   rem_q;
	logic [DEN_W-1:0]   den_q;
	logic [DEN_W:0]     rem_sh;
	logic               ge;
	logic [DEN_W:0]     rem_nx;

	// Restoring step: shift in one dividend bit, subtract when it fits
	always_comb begin
		rem_sh = {rem_q, work_q[DVD_W-1]};
		ge     = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
	end

	// Control: count one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: quotient bits replace dividend bits as they shift out
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			den_q  <= divisor;
		end else if (busy_q) begin
			work_q <= {work_q[DVD_W-2:0], ge};
			rem_q  <= rem_nx[DEN_W-1:0];
		end
	end

	assign quotient  = work_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

[rtl/hse_mulq.sv]
module hse_mulq import hse_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] a,
	input  logic signed [63:0] t,
	output logic signed [63:0] result,
	output logic               clip,
	output unit_stat_t         stat
);

	logic         busy_q;
	logic         done_q;
	logic [1:0]   k_q;
	logic [63:0]  am_q;
	logic [63:0]  tm_q;
	logic         neg_q;
	logic [127:0] acc_q;
	logic [31:0]  pa;
	logic [31:0]  pt;
	logic [63:0]  prod;
	logic [127:0] prod_sh;
	logic [63:0]  mag_r;

	// One 32x32 partial product per cycle, placed at its weight
	always_comb begin
		pa   = k_q[0] ? am_q[63:32] : am_q[31:0];
		pt   = k_q[1] ? tm_q[63:32] : tm_q[31:0];
		prod = pa * pt;
		unique case (k_q)
			2'd0:    prod_sh = {64'b0, prod};
			2'd3:    prod_sh = {prod, 64'b0};
			default: prod_sh = {32'b0, prod, 32'b0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (busy_q) begin
				k_q <= k_q + 1'b1;
				if (k_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Latch magnitudes and sign, accumulate partial products
	always_ff @(posedge clk) begin
		if (start) begin
			am_q  <= a[63] ? (64'd0 - a) : a;
			tm_q  <= t[63] ? (64'd0 - t) : t;
			neg_q <= a[63] ^ t[63];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + prod_sh;
		end
	end

	// Scale by 2^-32, clip, restore sign
	always_comb begin
		clip   = |acc_q[127:94];
		mag_r  = clip ? LIM : {2'b0, acc_q[93:32]};
		result = neg_q ? (64'sd0 - signed'(mag_r)) : signed'(mag_r);
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

[rtl/hermite_spline_evaluator.sv]
// A query's time is set by two 80-step bit-serial divisions (segment parameter, gradient)
// and five Horner multiplies of four partial products each; a zero-width segment skips them.
// One request is in work at a time; a knot load is finished in the idle state.
// A finished result waits in the output register while the next request is accepted.
// Reset: knot_count returns to 2, control clears; knot table is undefined until loaded.
module hermite_spline_evaluator import hse_pkg::*; #(
	parameter int MAX_KNOTS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         knot_count_we,
	input  logic [6:0]   knot_count_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// knot_index[5:0], knot_x_in[37:6], knot_y_in[69:38], knot_slope_in[101:70],
	// query_x[133:102], zero pad
	input  logic [135:0] s_axis_tdata,
	// req_type[0]
	input  logic [0:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// value_out[31:0], gradient_out[63:32], segment_out[69:64], zero pad
	output logic [71:0]  m_axis_tdata,
	// in_range[0], saturated[1]
	output logic [1:0]   m_axis_tuser
);

	localparam int AW = $clog2(MAX_KNOTS);
	localparam int CW = $clog2(MAX_KNOTS + 1);

	// Request fields
	logic        req_type;
	logic [5:0]  knot_index;
	knot_t       knot_in;
	logic signed [31:0] query_x;

	assign req_type      = s_axis_tuser[0];
	assign knot_index    = s_axis_tdata[5:0];
	assign knot_in.x     = s_axis_tdata[37:6];
	assign knot_in.y     = s_axis_tdata[69:38];
	assign knot_in.slope = s_axis_tdata[101:70];
	assign query_x       = s_axis_tdata[133:102];

	seq_state_t state_q, state_d;
	logic [6:0] knot_count_q;

	logic signed [31:0] xq_q;
	logic [CW-1:0] n_q, lo_q, hi_q, seg_q;
	logic [31:0]   x_first_q;
	logic          in_range_q;
	knot_t         k0_q;
	logic [31:0]   s1_q;
	logic signed [32:0] h_q, d_q, dy_q;
	logic signed [63:0] a1_q, b1_q, a2_q, a3_q, t_q, acc_q, val_q;
	horner_step_t  step_q;
	logic          clip_q;
	logic [31:0]   res_val_q, res_grad_q;

	logic          out_valid_q;
	logic [31:0]   val_out_q, grad_out_q;
	logic [5:0]    seg_out_q;
	logic          in_range_out_q, sat_out_q;

	logic accept, query_acc, mem_we;
	logic [CW:0]   lohi_sum;
	logic [CW-1:0] mid, n_m2, seg_c, n_c;
	logic          cont;
	logic [AW-1:0] rd_addr;
	knot_t         rd_data;
	logic signed [32:0] h_c, d_c, dy_c;
	logic [32:0]   h_mag, d_mag;
	logic [31:0]   s_sel, s_mag;
	logic [64:0]   coef_prod;
	logic signed [63:0] coef, dy64;
	logic signed [63:0] mul_op, addend, sum, sum_c, q_mag;
	logic          sum_clip;
	logic          mul_start, div_start, mul_clip;
	logic signed [63:0] mul_res;
	unit_stat_t    mul_stat, div_stat;
	logic [DVD_W-1:0] div_dvd, quot;
	logic          t_over, g_neg, g_clip, v_clip, fin_load;
	logic [63:0]   ut;
	logic [31:0]   g_res, v_res;

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept    = s_axis_tvalid && s_axis_tready;
	assign query_acc = accept && req_type;
	assign mem_we    = accept && !req_type && ({26'b0, knot_index} < 32'(MAX_KNOTS));
	assign fin_load  = (state_q == S_FIN) && (!out_valid_q || m_axis_tready);

	// Knot count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			knot_count_q <= 7'd2;
		end else if (knot_count_we) begin
			knot_count_q <= knot_count_wdata;
		end
	end

	// Search arithmetic and clamps
	always_comb begin
		if (knot_count_q < 7'd2) begin
			n_c = CW'(2);
		end else if ({25'b0, knot_count_q} > 32'(MAX_KNOTS)) begin
			n_c = CW'(MAX_KNOTS);
		end else begin
			n_c = CW'(knot_count_q);
		end
		lohi_sum = {1'b0, lo_q} + {1'b0, hi_q};
		mid      = lohi_sum[CW:1];
		cont     = ({1'b0, lo_q} + 1'b1) < {1'b0, hi_q};
		n_m2     = n_q - CW'(2);
		seg_c    = (lo_q > n_m2) ? n_m2 : lo_q;
	end

	// Table read address per state
	always_comb begin
		unique case (state_q)
			S_RD0:   rd_addr = AW'(n_q - 1'b1);
			S_SCHK:  rd_addr = cont ? AW'(mid) : AW'(seg_c);
			S_K0:    rd_addr = AW'(seg_q + 1'b1);
			default: rd_addr = '0;
		endcase
	end

	hse_knot_mem #(
		.DEPTH (MAX_KNOTS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (AW'(knot_index)),
		.wdata (knot_in),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Segment geometry and coefficients
	always_comb begin
		h_c   = $signed({rd_data.x[31], rd_data.x}) - $signed({k0_q.x[31], k0_q.x});
		d_c   = $signed({xq_q[31], xq_q}) - $signed({k0_q.x[31], k0_q.x});
		dy_c  = $signed({rd_data.y[31], rd_data.y}) - $signed({k0_q.y[31], k0_q.y});
		h_mag = h_q[32] ? (33'd0 - h_q) : h_q;
		d_mag = d_q[32] ? (33'd0 - d_q) : d_q;
		s_sel = (state_q == S_CA) ? k0_q.slope : s1_q;
		s_mag = s_sel[31] ? (32'd0 - s_sel) : s_sel;
		coef_prod = h_mag * s_mag;
		coef  = (h_q[32] ^ s_sel[31]) ? (64'sd0 - signed'({15'b0, coef_prod[64:16]}))
		                              : signed'({15'b0, coef_prod[64:16]});
		dy64  = 64'(dy_q);
	end

	// Horner operand and addend per step
	always_comb begin
		unique case (step_q)
			HS_V_CUBE: mul_op = a3_q;
			HS_G_QUAD: mul_op = (a3_q <<< 1) + a3_q;
			default:   mul_op = acc_q;
		endcase
		unique case (step_q)
			HS_V_CUBE: addend = a2_q;
			HS_V_LIN:  addend = 64'(signed'(k0_q.y));
			HS_G_QUAD: addend = a2_q <<< 1;
			default:   addend = a1_q;
		endcase
		sum      = mul_res + addend;
		sum_clip = (sum > LIM) || (sum < -LIM);
		sum_c    = (sum > LIM) ? LIM : ((sum < -LIM) ? -LIM : sum);
		q_mag    = sum_c[63] ? (64'sd0 - sum_c) : sum_c;
	end

	assign mul_start = (state_q == S_MST);
	assign div_start = (state_q == S_CC) ||
	                   ((state_q == S_MUL) && mul_stat.done && (step_q == HS_G_LIN));
	assign div_dvd   = (state_q == S_CC) ? {15'b0, d_mag, 32'b0}
	                                     : {1'b0, q_mag[62:0], 16'b0};

	hse_mulq u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_op),
		.t      (t_q),
		.result (mul_res),
		.clip   (mul_clip),
		.stat   (mul_stat)
	);

	hse_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (h_mag),
		.quotient (quot),
		.stat     (div_stat)
	);

	// Parameter t, gradient and value saturation
	always_comb begin
		t_over = |quot[DVD_W-1:62];
		ut     = t_over ? LIM : {2'b0, quot[61:0]};
		g_neg  = acc_q[63] ^ h_q[32];
		if (g_neg) begin
			g_clip = quot > DVD_W'(33'h0_8000_0000);
			g_res  = g_clip ? 32'h8000_0000 : (32'd0 - quot[31:0]);
		end else begin
			g_clip = |quot[DVD_W-1:31];
			g_res  = g_clip ? 32'h7FFF_FFFF : quot[31:0];
		end
		if (val_q > 64'sd2147483647) begin
			v_clip = 1'b1;
			v_res  = 32'h7FFF_FFFF;
		end else if (val_q < -64'sd2147483648) begin
			v_clip = 1'b1;
			v_res  = 32'h8000_0000;
		end else begin
			v_clip = 1'b0;
			v_res  = val_q[31:0];
		end
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (query_acc) state_d = S_RD0;
			S_RD0:  state_d = S_RDN;
			S_RDN:  state_d = S_SCHK;
			S_SCHK: state_d = cont ? S_SCMP : S_K0;
			S_SCMP: state_d = S_SCHK;
			S_K0:   state_d = S_K1;
			S_K1:   state_d = (h_c == 33'sd0) ? S_FIN : S_CA;
			S_CA:   state_d = S_CB;
			S_CB:   state_d = S_CC;
			S_CC:   state_d = S_TDIV;
			S_TDIV: if (div_stat.done) state_d = S_MST;
			S_MST:  state_d = S_MUL;
			S_MUL: begin
				if (mul_stat.done) begin
					state_d = (step_q == HS_G_LIN) ? S_GDIV : S_MST;
				end
			end
			S_GDIV: if (div_stat.done) state_d = S_FIN;
			S_FIN:  if (fin_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Query datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				xq_q   <= query_x;
				n_q    <= n_c;
				clip_q <= 1'b0;
			end
			S_RD0: x_first_q <= rd_data.x;
			S_RDN: begin
				in_range_q <= (xq_q >= signed'(x_first_q)) && (xq_q <= signed'(rd_data.x));
				lo_q <= '0;
				hi_q <= n_q;
			end
			S_SCHK: seg_q <= seg_c;
			S_SCMP: begin
				if (xq_q >= signed'(rd_data.x)) begin
					lo_q <= mid;
				end else begin
					hi_q <= mid;
				end
			end
			S_K0: k0_q <= rd_data;
			S_K1: begin
				h_q  <= h_c;
				d_q  <= d_c;
				dy_q <= dy_c;
				s1_q <= rd_data.slope;
				res_val_q  <= k0_q.y;
				res_grad_q <= k0_q.slope;
			end
			S_CA: a1_q <= coef;
			S_CB: b1_q <= coef;
			S_CC: begin
				a2_q <= (dy64 <<< 1) + dy64 - (a1_q <<< 1) - b1_q;
				a3_q <= a1_q + b1_q - (dy64 <<< 1);
			end
			S_TDIV: begin
				if (div_stat.done) begin
					t_q    <= (d_q[32] ^ h_q[32]) ? (64'sd0 - signed'(ut)) : signed'(ut);
					clip_q <= clip_q | t_over;
					step_q <= HS_V_CUBE;
				end
			end
			S_MUL: begin
				if (mul_stat.done) begin
					acc_q  <= sum_c;
					clip_q <= clip_q | mul_clip | sum_clip;
					if (step_q == HS_V_LIN) begin
						val_q <= sum_c;
					end
					if (step_q != HS_G_LIN) begin
						step_q <= horner_step_t'(step_q + 1'b1);
					end
				end
			end
			S_GDIV: begin
				if (div_stat.done) begin
					res_val_q  <= v_res;
					res_grad_q <= g_res;
					clip_q     <= clip_q | g_clip | v_clip;
				end
			end
			default: ;
		endcase
	end

	// Output register: load on finish, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			val_out_q      <= res_val_q;
			grad_out_q     <= res_grad_q;
			seg_out_q      <= 6'(seg_q);
			in_range_out_q <= in_range_q;
			sat_out_q      <= clip_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b0, seg_out_q, grad_out_q, val_out_q};
	assign m_axis_tuser  = {sat_out_q, in_range_out_q};

	// Checks
	a_query_starts: assert property (@(posedge clk) disable iff (!arst_n)
		query_acc |=> state_q == S_RD0)
		else $error("query request did not start the table reads");
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");
	a_mul_free: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_stat.busy)
		else $error("multiplier started while busy");
	a_search_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCHK |-> (lo_q < hi_q) && (hi_q <= n_q))
		else $error("search window out of order");
	a_seg_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_K0 |-> seg_q <= n_q - CW'(2))
		else $error("segment beyond last cubic");

endmodule
